// ===== sv/nlms_echo_canceller_core_assert.svh =====
// ----------------------------------------------------------------------------
// NLMS echo canceller assertion macros
// Shared property wrappers for the echo canceller RTL. They are empty when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NLMS_ECHO_CANCELLER_CORE_ASSERT_SVH
`define NLMS_ECHO_CANCELLER_CORE_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define NEC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nec: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nec: next-cycle check failed");

`else

`define NEC_ASSERT_SAME(lbl, ante, cons)
`define NEC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/nec_pkg.sv =====
// ----------------------------------------------------------------------------
// NLMS echo canceller package
// Widths, reset values, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package nec_pkg;

    // Default length of the adaptive filter.
    localparam int TapsDefault = 128;

    // Field and register widths.
    localparam int SampleW  = 16;
    localparam int WeightW  = 32;
    localparam int StepW    = 15;
    localparam int ThreshW  = 30;
    localparam int CfgDataW = 30;
    localparam int CfgIdxW  = 1;

    // Configuration reset values.
    localparam logic [StepW-1:0]   StepResetVal   = 15'd9830;
    localparam logic [ThreshW-1:0] ThreshResetVal = 30'd50;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgStepSize       = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgAdaptThreshold = 1'b1;

    // Shared multiplier operand and product widths.
    localparam int MulAW = 48;
    localparam int MulBW = 16;
    localparam int ProdW = 64;

    // Quotient bits of the step divider and the width of its counter.
    localparam int DivBits = 46;
    localparam int DivCntW = 6;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_OLD,
        S_SQ_OLD,
        S_SQ_NEW,
        S_SQ_ADD,
        S_MAC,
        S_DECIDE,
        S_STEP,
        S_ABS,
        S_DIVCHK,
        S_DIV,
        S_SCALE,
        S_UPD,
        S_DONE
    } nec_state_t;

endpackage

// ===== sv/nec_ram.sv =====
// ----------------------------------------------------------------------------
// NLMS echo canceller generic RAM
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module nec_ram #(
    parameter int Width = 32,
    parameter int Depth = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/nlms_echo_canceller_core.sv =====
// ----------------------------------------------------------------------------
// NLMS echo canceller core
// Adaptive FIR echo canceller: subtracts the echo estimate from each
// microphone sample and adapts the tap weights by the normalised LMS rule.
//
//   Channel  | Handshake                  | Word
//   ---------+----------------------------+-----------------------------
//   sample   | sample_valid, sample_ready | mic_sample, ref_sample
//   clean    | clean_valid, clean_ready   | clean_sample
//   config   | cfg_wr_en (no wait)        | cfg_index, cfg_wdata
//
// Each sample word is worked by one shared 48x16 multiplier that walks the two
// tap memories and, when it adapts, by a one-bit-per-cycle step divider that is
// skipped when the step saturates; the next sample word is taken once the
// sequencer is back in idle.
// After reset a clearing pass zeroes both memories before the first sample
// word is taken.
// A new sample word is taken while the previous clean word still waits on
// clean_ready; a stalled output holds the sequencer in its last state.
// ----------------------------------------------------------------------------
`include "nlms_echo_canceller_core_assert.svh"

module nlms_echo_canceller_core #(
    parameter int TAPS = nec_pkg::TapsDefault
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [nec_pkg::SampleW-1:0]    mic_sample,
    input  logic signed [nec_pkg::SampleW-1:0]    ref_sample,
    output logic                                  clean_valid,
    input  logic                                  clean_ready,
    output logic signed [nec_pkg::SampleW-1:0]    clean_sample,
    input  logic                                  cfg_wr_en,
    input  logic [nec_pkg::CfgIdxW-1:0]           cfg_index,
    input  logic [nec_pkg::CfgDataW-1:0]          cfg_wdata
);

    import nec_pkg::*;

    localparam int AW   = $clog2(TAPS);
    localparam int CW   = $clog2(TAPS + 1);
    localparam int EW   = 31 + $clog2(TAPS);
    localparam int AccW = 48 + $clog2(TAPS);
    localparam int ThrW = ThreshW + $clog2(TAPS + 1);
    localparam int CmpW = ThrW + 1;
    localparam int QcW  = AccW - 30;
    localparam int QeW  = AccW - 15;
    localparam int DsW  = EW + 30;

    // Sequencer and control state.
    nec_state_t          state_reg;
    nec_state_t          state_next;
    logic [CW-1:0]       cnt_reg;
    logic [2:0]          pv_reg;
    logic [AW-1:0]       ptr_reg;
    logic [AW-1:0]       addr_reg;
    logic [EW-1:0]       energy_reg;
    logic                clean_valid_reg;
    logic [StepW-1:0]    step_size_reg;
    logic [ThreshW-1:0]  adapt_threshold_reg;

    // Datapath registers.
    logic [SampleW-1:0]  ref_reg;
    logic [AccW-1:0]     acc_reg;
    logic [ProdW-1:0]    prod_reg;
    logic [AW-1:0]       a1_reg;
    logic [AW-1:0]       a2_reg;
    logic [AW-1:0]       a3_reg;
    logic [WeightW-1:0]  w1_reg;
    logic [WeightW-1:0]  w2_reg;
    logic [MulAW-1:0]    delta_reg;
    logic [SampleW-1:0]  clean_pend_reg;
    logic [SampleW-1:0]  clean_reg;
    logic [WeightW-1:0]  e15_reg;
    logic [DivBits-1:0]  p_mag_reg;
    logic                neg_reg;
    logic                sat_reg;
    logic [EW-1:0]       rem_reg;
    logic [DivBits-1:0]  quo_reg;
    logic [DivCntW-1:0]  div_cnt_reg;
    logic [MulAW-1:0]    s46_reg;

    // Combinational control.
    logic                accept;
    logic                issue;
    logic                walk_done;
    logic                out_load;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wgt_raddr;
    logic [AW-1:0]       ptr_dec;
    logic [AW-1:0]       addr_inc;
    logic                hist_we;
    logic [AW-1:0]       hist_waddr;
    logic [SampleW-1:0]  hist_wdata;
    logic [SampleW-1:0]  hist_rdata;
    logic                wgt_we;
    logic [AW-1:0]       wgt_waddr;
    logic [WeightW-1:0]  wgt_wdata;
    logic [WeightW-1:0]  wgt_rdata;

    // Shared multiplier.
    logic signed [MulAW-1:0] mul_a;
    logic signed [MulBW-1:0] mul_b;
    logic signed [ProdW-1:0] prod_next;

    // Arithmetic helpers.
    logic [QcW-1:0]      q30;
    logic [QcW-1:0]      q30r;
    logic                up30;
    logic [SampleW-1:0]  clean_sat;
    logic [QeW-1:0]      q15;
    logic [QeW-1:0]      q15r;
    logic                up15;
    logic [WeightW-1:0]  e15_sat;
    logic [MulAW-1:0]    qd;
    logic                upd;
    logic [MulAW-1:0]    delta_next;
    logic [WeightW+16:0] wsum;
    logic [WeightW-1:0]  wsum_sat;
    logic [ThrW-1:0]     thr_prod;
    logic                adapt;
    logic [ProdW-1:0]    p_abs;
    logic                div_sat;
    logic [EW:0]         trial;
    logic [EW:0]         trial_diff;
    logic                trial_ge;
    logic [MulAW-1:0]    s46_next;

    assign accept       = sample_valid && sample_ready;
    assign clean_valid  = clean_valid_reg;
    assign clean_sample = clean_reg;

    // Address arithmetic on the circular delay line, newest sample at ptr.
    assign ptr_dec   = (ptr_reg == '0) ? AW'(TAPS - 1) : ptr_reg - AW'(1);
    assign addr_inc  = (addr_reg == AW'(TAPS - 1)) ? '0 : addr_reg + AW'(1);
    assign walk_done = (cnt_reg == CW'(TAPS)) && (pv_reg == '0);

    // Weights are held by tap index, so they are read at the tap count.
    assign wgt_raddr = cnt_reg[AW-1:0];

    // Tap memories.
    nec_ram #(
        .Width (SampleW),
        .Depth (TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (rd_addr),
        .rdata (hist_rdata)
    );

    nec_ram #(
        .Width (WeightW),
        .Depth (TAPS)
    ) u_wgt_ram (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (wgt_waddr),
        .wdata (wgt_wdata),
        .raddr (wgt_raddr),
        .rdata (wgt_rdata)
    );

    // The one multiplier, shared by every product in the algorithm but the threshold scaling.
    assign prod_next = ProdW'(mul_a) * ProdW'(mul_b);

    // Error rounded to an integer, ties to even, then saturated to 16 bits.
    assign q30  = acc_reg[AccW-1:30];
    assign up30 = (acc_reg[29:0] > {1'b1, 29'b0})
               || ((acc_reg[29:0] == {1'b1, 29'b0}) && q30[0]);
    assign q30r = q30 + QcW'(up30);

    always_comb
    begin
        if ((&q30r[QcW-1:SampleW-1]) || (~|q30r[QcW-1:SampleW-1]))
        begin
            clean_sat = q30r[SampleW-1:0];
        end
        else
        begin
            clean_sat = q30r[QcW-1] ? {1'b1, {(SampleW-1){1'b0}}}
                                    : {1'b0, {(SampleW-1){1'b1}}};
        end
    end

    // Error rounded to Q15, ties to even, then saturated to 32 bits.
    assign q15  = acc_reg[AccW-1:15];
    assign up15 = (acc_reg[14:0] > {1'b1, 14'b0})
               || ((acc_reg[14:0] == {1'b1, 14'b0}) && q15[0]);
    assign q15r = q15 + QeW'(up15);

    always_comb
    begin
        if ((&q15r[QeW-1:WeightW-1]) || (~|q15r[QeW-1:WeightW-1]))
        begin
            e15_sat = q15r[WeightW-1:0];
        end
        else
        begin
            e15_sat = q15r[QeW-1] ? {1'b1, {(WeightW-1){1'b0}}}
                                  : {1'b0, {(WeightW-1){1'b1}}};
        end
    end

    // Weight increment: step times sample rounded to Q30, ties to even.
    assign qd         = prod_reg[ProdW-1:16];
    assign upd        = (prod_reg[15:0] > 16'h8000)
                     || ((prod_reg[15:0] == 16'h8000) && qd[0]);
    assign delta_next = qd + MulAW'(upd);

    // Updated weight, saturated to 32 bits.
    assign wsum = {{(17){w2_reg[WeightW-1]}}, w2_reg} + {delta_reg[MulAW-1], delta_reg};

    always_comb
    begin
        if ((&wsum[WeightW+16:WeightW-1]) || (~|wsum[WeightW+16:WeightW-1]))
        begin
            wsum_sat = wsum[WeightW-1:0];
        end
        else
        begin
            wsum_sat = wsum[WeightW+16] ? {1'b1, {(WeightW-1){1'b0}}}
                                        : {1'b0, {(WeightW-1){1'b1}}};
        end
    end

    // Adaptation only when the energy is above threshold times tap count.
    assign thr_prod = ThrW'(adapt_threshold_reg) * ThrW'(TAPS);
    assign adapt    = CmpW'(energy_reg) > CmpW'(thr_prod);

    // Step divider: magnitude, overflow check and one quotient bit a cycle.
    assign p_abs      = prod_reg[ProdW-1] ? (~prod_reg + ProdW'(1)) : prod_reg;
    assign div_sat    = DsW'(p_mag_reg) >= {energy_reg, 30'b0};
    assign trial      = {rem_reg, quo_reg[DivBits-1]};
    assign trial_ge   = trial >= {1'b0, energy_reg};
    assign trial_diff = trial - {1'b0, energy_reg};

    always_comb
    begin
        if (sat_reg)
        begin
            s46_next = neg_reg ? {2'b11, {DivBits{1'b0}}} : {2'b00, {DivBits{1'b1}}};
        end
        else
        begin
            s46_next = neg_reg ? (~{2'b00, quo_reg} + MulAW'(1)) : {2'b00, quo_reg};
        end
    end

    // Next state, memory ports and multiplier operands.
    always_comb
    begin
        state_next   = state_reg;
        sample_ready = 1'b0;
        issue        = 1'b0;
        out_load     = 1'b0;
        rd_addr      = addr_reg;
        hist_we      = 1'b0;
        hist_waddr   = ptr_reg;
        hist_wdata   = ref_reg;
        wgt_we       = 1'b0;
        wgt_waddr    = a3_reg;
        wgt_wdata    = wsum_sat;
        mul_a        = {{(MulAW-WeightW){wgt_rdata[WeightW-1]}}, wgt_rdata};
        mul_b        = hist_rdata;
        unique case (state_reg)
            S_CLEAR:
            begin
                hist_we    = 1'b1;
                hist_waddr = cnt_reg[AW-1:0];
                hist_wdata = '0;
                wgt_we     = 1'b1;
                wgt_waddr  = cnt_reg[AW-1:0];
                wgt_wdata  = '0;
                if (cnt_reg == CW'(TAPS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    state_next = S_OLD;
                end
            end
            S_OLD:
            begin
                rd_addr    = ptr_reg;
                state_next = S_SQ_OLD;
            end
            S_SQ_OLD:
            begin
                mul_a      = {{(MulAW-SampleW){hist_rdata[SampleW-1]}}, hist_rdata};
                hist_we    = 1'b1;
                state_next = S_SQ_NEW;
            end
            S_SQ_NEW:
            begin
                mul_a      = {{(MulAW-SampleW){ref_reg[SampleW-1]}}, ref_reg};
                mul_b      = ref_reg;
                state_next = S_SQ_ADD;
            end
            S_SQ_ADD:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                issue = cnt_reg < CW'(TAPS);
                if (walk_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = adapt ? S_STEP : S_DONE;
            end
            S_STEP:
            begin
                mul_a      = {{(MulAW-WeightW){e15_reg[WeightW-1]}}, e15_reg};
                mul_b      = {1'b0, step_size_reg};
                state_next = S_ABS;
            end
            S_ABS:
            begin
                state_next = S_DIVCHK;
            end
            S_DIVCHK:
            begin
                state_next = div_sat ? S_SCALE : S_DIV;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DivCntW'(1))
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                issue  = cnt_reg < CW'(TAPS);
                mul_a  = s46_reg;
                wgt_we = pv_reg[2];
                if (walk_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!clean_valid_reg || clean_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers, set to their reset values by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_CLEAR;
            cnt_reg             <= '0;
            pv_reg              <= '0;
            ptr_reg             <= '0;
            addr_reg            <= '0;
            energy_reg          <= '0;
            clean_valid_reg     <= 1'b0;
            step_size_reg       <= StepResetVal;
            adapt_threshold_reg <= ThreshResetVal;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= {pv_reg[1:0], issue};

            // Tap counter: clearing pass, then one count per issued read; cleared on accept and at the decision.
            if (state_reg == S_CLEAR || issue)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (accept || state_reg == S_DECIDE)
            begin
                cnt_reg <= '0;
            end

            // Delay line pointer and walking read address.
            if (accept)
            begin
                ptr_reg  <= ptr_dec;
                addr_reg <= ptr_dec;
            end
            else if (issue)
            begin
                addr_reg <= addr_inc;
            end
            else if (state_reg == S_DECIDE)
            begin
                addr_reg <= ptr_reg;
            end

            // Running energy: drop the oldest square, add the newest.
            if (state_reg == S_SQ_NEW)
            begin
                energy_reg <= energy_reg - prod_reg[EW-1:0];
            end
            else if (state_reg == S_SQ_ADD)
            begin
                energy_reg <= energy_reg + prod_reg[EW-1:0];
            end

            // Output word register.
            if (out_load)
            begin
                clean_valid_reg <= 1'b1;
            end
            else if (clean_ready)
            begin
                clean_valid_reg <= 1'b0;
            end

            // Configuration writes.
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CfgStepSize:
                    begin
                        step_size_reg <= cfg_wdata[StepW-1:0];
                    end
                    CfgAdaptThreshold:
                    begin
                        adapt_threshold_reg <= cfg_wdata[ThreshW-1:0];
                    end
                    default:
                    begin
                        step_size_reg <= step_size_reg;
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        a1_reg    <= wgt_raddr;
        a2_reg    <= a1_reg;
        a3_reg    <= a2_reg;
        w1_reg    <= wgt_rdata;
        w2_reg    <= w1_reg;
        delta_reg <= delta_next;

        // Capture the new word; the accumulator starts at mic * 2^30.
        if (accept)
        begin
            ref_reg <= ref_sample;
            acc_reg <= {{(AccW-SampleW-30){mic_sample[SampleW-1]}}, mic_sample, 30'b0};
        end
        else if (state_reg == S_MAC && pv_reg[1])
        begin
            acc_reg <= acc_reg - prod_reg[AccW-1:0];
        end

        if (state_reg == S_DECIDE)
        begin
            clean_pend_reg <= clean_sat;
            e15_reg        <= e15_sat;
        end

        if (state_reg == S_ABS)
        begin
            p_mag_reg <= p_abs[DivBits-1:0];
            neg_reg   <= prod_reg[ProdW-1];
        end

        // Divider load and iteration.
        if (state_reg == S_DIVCHK)
        begin
            sat_reg     <= div_sat;
            rem_reg     <= EW'(p_mag_reg[DivBits-1:30]);
            quo_reg     <= {p_mag_reg[29:0], 16'b0};
            div_cnt_reg <= DivCntW'(DivBits);
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg     <= trial_ge ? trial_diff[EW-1:0] : trial[EW-1:0];
            quo_reg     <= {quo_reg[DivBits-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg - DivCntW'(1);
        end

        if (state_reg == S_SCALE)
        begin
            s46_reg <= s46_next;
        end

        if (out_load)
        begin
            clean_reg <= clean_pend_reg;
        end
    end

    // Checks on the sequencer and the divider.
    `NEC_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready)
    `NEC_ASSERT_SAME(a_wgt_write_window, wgt_we, (state_reg == S_CLEAR) || (state_reg == S_UPD))
    `NEC_ASSERT_SAME(a_div_rem_below, state_reg == S_DIV, rem_reg < energy_reg)
    `NEC_ASSERT_SAME(a_out_from_done, $rose(clean_valid_reg), $past(state_reg == S_DONE))
    `NEC_ASSERT_SAME(a_mac_full_walk, (state_reg == S_MAC) && (state_next != S_MAC), cnt_reg == CW'(TAPS))

endmodule
